FILE: src/sols_pkg.sv
`timescale 1ns / 1ps

package sols_pkg;

   // table geometry
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] REG_LIST_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIT_POLICY  = 1'd1;

   // hit policy codes
   localparam logic [1:0] POLICY_NONE      = 2'd0;
   localparam logic [1:0] POLICY_TRANSPOSE = 2'd1;
   localparam logic [1:0] POLICY_FRONT     = 2'd2;

   // request kinds
   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   // table write port
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } tbl_wr_type;

endpackage

FILE: src/sols_table.sv
`timescale 1ns / 1ps

module sols_table
   import sols_pkg::*;
(
   input  logic              clock,
   input  tbl_wr_type        wr,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port (read before write)
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/self_organizing_list_search.sv
`timescale 1ns / 1ps
// write request: written to the table on acceptance, no response, ready again the next cycle
// search request: scans positions 0 to n-1 in order and responds on a miss or at the
// first hit; a swapped hit adds a swap read and a swap write; n is list_length capped at 32
// ready for the next request as the response goes out; one table read per cycle
// synchronous active-high reset clears the control state and both registers;
// table contents are undefined until written

module self_organizing_list_search
   import sols_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,   // entry_index[4:0], item_value[36:5], zero pad
   input  logic                  req_tuser,   // mode
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // hit_position[4:0], zero pad
   output logic                  rsp_tuser,   // found
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SCAN    = 5'b00010,
      S_SWAP_RD = 5'b00100,
      S_SWAP_WR = 5'b01000,
      S_RESP    = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  list_length_ff, list_length_in;
   logic [1:0]        hit_policy_ff, hit_policy_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  addr_ff, addr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]  partner_ff, partner_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]  rsp_pos_ff, rsp_pos_in;

   tbl_wr_type        tbl_wr;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              req_acc;
   logic              match;
   logic              do_swap;
   logic [IDX_W-1:0]  req_index;
   logic [DATA_W-1:0] req_value;

   assign req_index  = req_tdata[IDX_W-1:0];
   assign req_value  = req_tdata[IDX_W+DATA_W-1:IDX_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   sols_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared comparator against the entry read last cycle
   assign match   = cmp_vld_ff && (rd_data == key_ff);
   assign do_swap = ((hit_policy_ff == POLICY_TRANSPOSE) || (hit_policy_ff == POLICY_FRONT))
                    && (cmp_idx_ff != '0);

   // configuration registers
   always_comb begin
      list_length_in = list_length_ff;
      hit_policy_in  = hit_policy_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_LIST_LENGTH: list_length_in = csr_wdata[LEN_W-1:0];
            REG_HIT_POLICY:  hit_policy_in  = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      partner_in   = partner_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      tbl_wr       = '0;
      rd_addr      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == MODE_WRITE) begin
                  tbl_wr.we   = 1'b1;
                  tbl_wr.addr = req_index;
                  tbl_wr.data = req_value;
               end else begin
                  key_in   = req_value;
                  len_in   = (list_length_ff > LEN_W'(CAPACITY)) ? LEN_W'(CAPACITY)
                                                                 : list_length_ff;
                  addr_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // issue the next read while comparing the previous entry
            rd_addr    = addr_ff[IDX_W-1:0];
            cmp_vld_in = (addr_ff < len_ff);
            cmp_idx_in = addr_ff[IDX_W-1:0];
            addr_in    = addr_ff + LEN_W'(1);
            if (match) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               partner_in = (hit_policy_ff == POLICY_TRANSPOSE) ? cmp_idx_ff - IDX_W'(1)
                                                                : '0;
               cmp_vld_in = 1'b0;
               state_in   = do_swap ? S_SWAP_RD : S_RESP;
            end else if (addr_ff >= len_ff) begin
               hit_in     = 1'b0;
               hit_idx_in = '0;
               cmp_vld_in = 1'b0;
               state_in   = S_RESP;
            end
         end

         S_SWAP_RD: begin
            // read the partner and overwrite it with the key (the hit value)
            rd_addr     = partner_ff;
            tbl_wr.we   = 1'b1;
            tbl_wr.addr = partner_ff;
            tbl_wr.data = key_ff;
            state_in    = S_SWAP_WR;
         end

         S_SWAP_WR: begin
            // old partner value goes to the hit position
            tbl_wr.we   = 1'b1;
            tbl_wr.addr = hit_idx_ff;
            tbl_wr.data = rd_data;
            state_in    = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_pos_in   = hit_idx_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         list_length_ff <= '0;
         hit_policy_ff  <= POLICY_NONE;
         cmp_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         list_length_ff <= list_length_in;
         hit_policy_ff  <= hit_policy_in;
         cmp_vld_ff     <= cmp_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      len_ff       <= len_in;
      addr_ff      <= addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      partner_ff   <= partner_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(8 - IDX_W){1'b0}}, rsp_pos_ff};

endmodule
